### src/cota_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cota_pkg: shared constants and types of the object table allocator
// field widths, status codes, function codes and the table entry layout
// ----------------------------------------------------------------------------
package cota_pkg;

   localparam int MAX_OBJECTS = 64;
   localparam int HEAP_BYTES  = 1048576;
   localparam int ID_W        = $clog2(MAX_OBJECTS);
   localparam int CNT_W       = $clog2(MAX_OBJECTS + 1);
   localparam int SIZE_W      = 21;
   localparam int OFF_W       = 20;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_SPACE   = 3'd1;
   localparam logic [2:0] ST_ENTRIES = 3'd2;
   localparam logic [2:0] ST_SIZE    = 3'd3;
   localparam logic [2:0] ST_ID      = 3'd4;

   localparam logic [1:0] FN_ADD    = 2'd0;
   localparam logic [1:0] FN_FREE   = 2'd1;
   localparam logic [1:0] FN_RESIZE = 2'd2;
   localparam logic [1:0] FN_READ   = 2'd3;

   localparam logic [1:0] REG_ALLOW = 2'd0;
   localparam logic [1:0] REG_PLIM  = 2'd1;
   localparam logic [1:0] REG_SLIM  = 2'd2;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic [OFF_W-1:0]  offset;
      logic              heap;
   } entry_type;

endpackage

### src/compacting_object_table_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_object_table_allocator
// ordered object table over two bump heaps, held in one synchronous memory
// ----------------------------------------------------------------------------
// Usage: requests (func, object_id, byte_count) enter on req_valid/req_ready.
// Each request gives exactly one response on rsp_valid/rsp_ready with a
// status, the entry fields, the heap move a DMA has to perform and the new
// live count. Registers are written on csr_valid/csr_ready (index, data);
// write them only while no request is in flight: the block does not enforce it.
// One request is handled at a time. Add and bad-id cases go from the idle
// state straight to the response state; read and resize outcomes without a
// walk pass through the read and evaluate states first. Free and resize read
// the target entry and then walk every later entry through the single
// memory port, reading each entry and writing it back in turn, so their
// time grows with the number of live entries after the target.
// After reset the table is empty, the heaps are unused and the registers
// hold their reset values; no clearing pass runs, entries at or above the
// live count are never used. The response sits in an output register;
// while the receiver stalls no new request is taken.
// ----------------------------------------------------------------------------
module compacting_object_table_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_func,
   input  logic [cota_pkg::ID_W-1:0]       req_object_id,
   input  logic [cota_pkg::SIZE_W-1:0]     req_byte_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_status,
   output logic [cota_pkg::ID_W-1:0]       rsp_assigned_id,
   output logic                            rsp_heap_select,
   output logic [cota_pkg::OFF_W-1:0]      rsp_entry_offset,
   output logic [cota_pkg::SIZE_W-1:0]     rsp_entry_bytes,
   output logic                            rsp_move_needed,
   output logic [cota_pkg::SIZE_W-1:0]     rsp_move_source,
   output logic [cota_pkg::SIZE_W-1:0]     rsp_move_dest,
   output logic [cota_pkg::SIZE_W-1:0]     rsp_move_length,
   output logic [cota_pkg::CNT_W-1:0]      rsp_live_count,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [cota_pkg::SIZE_W-1:0]     csr_data
);

   localparam int SW = cota_pkg::SIZE_W;
   localparam int OW = cota_pkg::OFF_W;
   localparam int IW = cota_pkg::ID_W;
   localparam int CW = cota_pkg::CNT_W;
   localparam logic [SW-1:0] HEAP_MAX = SW'(cota_pkg::HEAP_BYTES);

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_EVAL, S_WREAD, S_WPROC, S_RESP
   } state_type;

   state_type state_ff;
   cota_pkg::entry_type mem [cota_pkg::MAX_OBJECTS];
   cota_pkg::entry_type rdata_ff;

   logic              allow_ff;
   logic [SW-1:0]     plim_ff, slim_ff;
   logic [CW-1:0]     total_ff;
   logic [SW-1:0]     used0_ff, used1_ff;

   logic [1:0]        func_ff;
   logic [IW-1:0]     id_ff;
   logic [SW-1:0]     bytes_ff;
   logic              h_ff;
   logic [SW-1:0]     old_ff;     // size of the target entry
   logic [IW-1:0]     k_ff;       // walk index
   logic              found_ff;
   logic [OW-1:0]     off_ff;

   // memory port
   logic              we;
   logic [IW-1:0]     waddr, raddr;
   cota_pkg::entry_type wdata;
   logic              re;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   // limits
   logic [SW-1:0] lim0, lim1, lim_h, used_h;
   assign lim0   = (plim_ff > HEAP_MAX) ? HEAP_MAX : plim_ff;
   assign lim1   = (slim_ff > HEAP_MAX) ? HEAP_MAX : slim_ff;
   assign lim_h  = h_ff ? lim1 : lim0;
   assign used_h = h_ff ? used1_ff : used0_ff;

   logic [SW:0] add0_sum, add1_sum, rs_sum;
   assign add0_sum = {1'b0, used0_ff} + {1'b0, req_byte_count};
   assign add1_sum = {1'b0, used1_ff} + {1'b0, req_byte_count};
   assign rs_sum   = {1'b0, used_h - old_ff} + {1'b0, bytes_ff};

   logic [SW-1:0] delta;
   assign delta = bytes_ff - old_ff;

   // add placement and request status
   logic       add_h, add_space, add_go;
   logic [2:0] add_status, req_status;
   assign add_h      = add0_sum > {1'b0, lim0};
   assign add_space  = add_h && !(allow_ff && !(add1_sum > {1'b0, lim1}));
   assign add_status = (req_byte_count == '0) ? cota_pkg::ST_SIZE :
                       add_space ? cota_pkg::ST_SPACE :
                       (total_ff >= CW'(cota_pkg::MAX_OBJECTS)) ? cota_pkg::ST_ENTRIES :
                       cota_pkg::ST_OK;
   assign req_status = (req_func == cota_pkg::FN_ADD) ? add_status :
                       ({1'b0, req_object_id} >= total_ff) ? cota_pkg::ST_ID :
                       cota_pkg::ST_OK;
   assign add_go     = (req_func == cota_pkg::FN_ADD) && (add_status == cota_pkg::ST_OK);

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid;
   assign csr_ready = 1'b1;

   logic last_k;
   assign last_k = ({1'b0, k_ff} + 1'b1) >= {1'b0, total_ff};

   // true when the walk has no entry to visit
   function automatic logic last_walk_start(input logic [IW-1:0] id,
                                            input logic [CW-1:0] tot);
      logic [CW:0] nx;
      nx = {1'b0, CW'(id)} + 1'b1;
      last_walk_start = nx >= {1'b0, tot};
   endfunction

   always_comb begin
      re = 1'b0; raddr = id_ff; we = 1'b0; waddr = k_ff; wdata = rdata_ff;
      if (state_ff == S_IDLE && req_valid && req_ready) begin
         re = 1'b1; raddr = req_object_id;
      end
      if (state_ff == S_WREAD) begin
         re = 1'b1;
         raddr = (func_ff == cota_pkg::FN_FREE) ? IW'(k_ff + 1'b1) : k_ff;
      end
      if (state_ff == S_WPROC) begin
         we = 1'b1; wdata = rdata_ff;
         if (rdata_ff.heap == h_ff) begin
            if (func_ff == cota_pkg::FN_FREE) wdata.offset = rdata_ff.offset - old_ff[OW-1:0];
            else wdata.offset = rdata_ff.offset + delta[OW-1:0];
         end
      end
      if (state_ff == S_EVAL && func_ff == cota_pkg::FN_RESIZE && bytes_ff != old_ff
          && bytes_ff != '0 && !(rs_sum > {1'b0, lim_h})) begin
         we = 1'b1; waddr = id_ff; wdata = rdata_ff; wdata.size = bytes_ff;
      end
      if (state_ff == S_IDLE && req_valid && req_ready && add_go) begin
         we = 1'b1; waddr = total_ff[IW-1:0];
         wdata.size = req_byte_count;
         if (!add_h) begin
            wdata.heap = 1'b0; wdata.offset = used0_ff[OW-1:0];
         end else begin
            wdata.heap = 1'b1; wdata.offset = used1_ff[OW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rsp_valid <= 1'b0;
         allow_ff <= 1'b0; plim_ff <= SW'(65536); slim_ff <= '0;
         total_ff <= '0; used0_ff <= '0; used1_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         if (csr_valid) begin
            case (csr_index)
               cota_pkg::REG_ALLOW: allow_ff <= csr_data[0];
               cota_pkg::REG_PLIM:  plim_ff  <= csr_data;
               cota_pkg::REG_SLIM:  slim_ff  <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  func_ff <= req_func; id_ff <= req_object_id; bytes_ff <= req_byte_count;
                  rsp_status <= req_status;
                  rsp_assigned_id <= (req_func == cota_pkg::FN_ADD) ?
                                     (add_go ? total_ff[IW-1:0] : '0) : req_object_id;
                  rsp_heap_select <= add_go && add_h;
                  rsp_entry_offset <= !add_go ? '0 :
                                      add_h ? used1_ff[OW-1:0] : used0_ff[OW-1:0];
                  rsp_entry_bytes <= add_go ? req_byte_count : '0;
                  rsp_move_needed <= 1'b0; rsp_move_source <= '0; rsp_move_dest <= '0;
                  rsp_move_length <= '0;
                  rsp_live_count <= add_go ? CW'(total_ff + 1'b1) : total_ff;
                  if (add_go) begin
                     total_ff <= total_ff + 1'b1;
                     if (add_h) used1_ff <= add1_sum[SW-1:0];
                     else used0_ff <= add0_sum[SW-1:0];
                  end
                  state_ff <= (req_func == cota_pkg::FN_ADD || req_status == cota_pkg::ST_ID)
                              ? S_RESP : S_RD;
               end
            end
            S_RD: begin
               h_ff <= rdata_ff.heap; old_ff <= rdata_ff.size; off_ff <= rdata_ff.offset;
               state_ff <= S_EVAL;
            end
            S_EVAL: begin
               found_ff <= 1'b0;
               case (func_ff)
                  cota_pkg::FN_READ: begin
                     rsp_heap_select <= rdata_ff.heap;
                     rsp_entry_offset <= rdata_ff.offset;
                     rsp_entry_bytes <= rdata_ff.size;
                     state_ff <= S_RESP;
                  end
                  cota_pkg::FN_FREE: begin
                     rsp_heap_select <= rdata_ff.heap;
                     rsp_entry_offset <= rdata_ff.offset;
                     if (rdata_ff.heap) used1_ff <= used1_ff - rdata_ff.size;
                     else used0_ff <= used0_ff - rdata_ff.size;
                     total_ff <= total_ff - 1'b1;
                     rsp_live_count <= total_ff - 1'b1;
                     k_ff <= id_ff;
                     state_ff <= last_walk_start(id_ff, total_ff) ? S_RESP : S_WREAD;
                  end
                  default: begin
                     if (bytes_ff == rdata_ff.size) begin
                        rsp_heap_select <= rdata_ff.heap;
                        rsp_entry_offset <= rdata_ff.offset;
                        rsp_entry_bytes <= rdata_ff.size;
                        state_ff <= S_RESP;
                     end else if (bytes_ff == '0) begin
                        rsp_status <= cota_pkg::ST_SIZE;
                        state_ff <= S_RESP;
                     end else if (rs_sum > {1'b0, lim_h}) begin
                        rsp_status <= cota_pkg::ST_SPACE;
                        state_ff <= S_RESP;
                     end else begin
                        rsp_heap_select <= rdata_ff.heap;
                        rsp_entry_offset <= rdata_ff.offset;
                        rsp_entry_bytes <= bytes_ff;
                        if (rdata_ff.heap) used1_ff <= rs_sum[SW-1:0];
                        else used0_ff <= rs_sum[SW-1:0];
                        k_ff <= IW'(id_ff + 1'b1);
                        state_ff <= last_walk_start(id_ff, total_ff) ? S_RESP : S_WREAD;
                     end
                  end
               endcase
            end
            S_WREAD: state_ff <= S_WPROC;
            S_WPROC: begin
               // first later entry in the same heap gives the move
               if (!found_ff && rdata_ff.heap == h_ff) begin
                  found_ff <= 1'b1;
                  rsp_move_source <= SW'(rdata_ff.offset);
                  if (func_ff == cota_pkg::FN_FREE) begin
                     rsp_move_dest <= SW'(off_ff);
                     rsp_move_length <= used_h - SW'(rdata_ff.offset) + old_ff;
                     rsp_move_needed <= (used_h + old_ff) != SW'(rdata_ff.offset);
                  end else begin
                     rsp_move_dest <= SW'(rdata_ff.offset) + delta;
                     rsp_move_length <= used_h - delta - SW'(rdata_ff.offset);
                     rsp_move_needed <= (used_h - delta) != SW'(rdata_ff.offset);
                  end
               end
               k_ff <= IW'(k_ff + 1'b1);
               if (func_ff == cota_pkg::FN_FREE) begin
                  // total already decremented: stop when k+1 reaches it
                  if (({1'b0, k_ff} + 1'b1) >= {1'b0, total_ff}) state_ff <= S_RESP;
                  else state_ff <= S_WREAD;
               end else if (last_k) state_ff <= S_RESP;
               else state_ff <= S_WREAD;
            end
            S_RESP: begin
               rsp_valid <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(cota_pkg::MAX_OBJECTS))
      else $error("live count past table depth");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WPROC |-> we)
      else $error("walk step without write back");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped under stall");

endmodule

### dv/compacting_object_table_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_object_table_allocator_test
// drives add, free, resize and read requests through a table of directed
// cases and then random traffic, predicts every response with an in-bench
// model of the table and both heaps, and compares each response field by field
// ----------------------------------------------------------------------------
module compacting_object_table_allocator_test;

   localparam int NUM_RANDOM  = 800;
   localparam int ID_W        = cota_pkg::ID_W;
   localparam int OFF_W       = cota_pkg::OFF_W;
   localparam int SIZE_W      = cota_pkg::SIZE_W;
   localparam int CNT_W       = cota_pkg::CNT_W;
   localparam int MAX_OBJECTS = cota_pkg::MAX_OBJECTS;
   localparam int HEAP_BYTES  = cota_pkg::HEAP_BYTES;

   typedef struct packed {
      logic [2:0]        status;
      logic [ID_W-1:0]   assigned_id;
      logic              heap_select;
      logic [OFF_W-1:0]  entry_offset;
      logic [SIZE_W-1:0] entry_bytes;
      logic              move_needed;
      logic [SIZE_W-1:0] move_source;
      logic [SIZE_W-1:0] move_dest;
      logic [SIZE_W-1:0] move_length;
      logic [CNT_W-1:0]  live_count;
   } response_type;

   typedef struct {
      logic [1:0]        func;
      logic [ID_W-1:0]   object_id;
      logic [SIZE_W-1:0] byte_count;
      bit                fixed;
      logic [2:0]        status;
   } request_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_func = cota_pkg::FN_ADD;
   logic [ID_W-1:0] req_object_id = '0;
   logic [SIZE_W-1:0] req_byte_count = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [ID_W-1:0] rsp_assigned_id;
   logic rsp_heap_select;
   logic [OFF_W-1:0] rsp_entry_offset;
   logic [SIZE_W-1:0] rsp_entry_bytes;
   logic rsp_move_needed;
   logic [SIZE_W-1:0] rsp_move_source;
   logic [SIZE_W-1:0] rsp_move_dest;
   logic [SIZE_W-1:0] rsp_move_length;
   logic [CNT_W-1:0] rsp_live_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = cota_pkg::REG_ALLOW;
   logic [SIZE_W-1:0] csr_data = '0;

   // predictor state
   logic [SIZE_W-1:0] size_tab [MAX_OBJECTS];
   logic [OFF_W-1:0]  offset_tab [MAX_OBJECTS];
   logic              heap_tab [MAX_OBJECTS];
   int unsigned       live_total;
   logic [SIZE_W-1:0] heap_used [2];
   logic              spill_enable;
   logic [SIZE_W-1:0] limit_reg [2];

   response_type expected_rsp [$];
   logic [2:0]   fixed_status [$];
   bit           fixed_valid [$];
   int unsigned  error_count = 0;
   int unsigned  response_count = 0;
   int unsigned  move_count = 0;
   bit           hold_off = 1'b0;

   compacting_object_table_allocator i_dut (.*);

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic logic [SIZE_W-1:0] cap_of(input logic h);
      return (limit_reg[h] > HEAP_BYTES) ? SIZE_W'(HEAP_BYTES) : limit_reg[h];
   endfunction

   function automatic void find_next(input int id, input logic h, output bit hit,
                                     output int at);
      hit = 0;
      at = 0;
      for (int j = id + 1; j < live_total; j++) begin
         if (heap_tab[j] == h) begin
            hit = 1;
            at = j;
            return;
         end
      end
   endfunction

   function automatic response_type predict_allocator(input logic [1:0] func,
                                                      input logic [ID_W-1:0] oid,
                                                      input logic [SIZE_W-1:0] bytes);
      response_type r;
      logic h;
      logic [SIZE_W-1:0] sz;
      logic [SIZE_W-1:0] src;
      bit hit;
      int at;
      r = '0;
      r.status = cota_pkg::ST_OK;
      r.assigned_id = oid;
      if (func == cota_pkg::FN_ADD) begin
         r.assigned_id = '0;
         h = 1'b0;
         if (bytes == 0) begin
            r.status = cota_pkg::ST_SIZE;
         end else begin
            if (32'(heap_used[0]) + bytes > cap_of(1'b0)) begin
               if (spill_enable && 32'(heap_used[1]) + bytes <= cap_of(1'b1)) h = 1'b1;
               else r.status = cota_pkg::ST_SPACE;
            end
            if (r.status == cota_pkg::ST_OK && live_total >= MAX_OBJECTS)
               r.status = cota_pkg::ST_ENTRIES;
         end
         if (r.status == cota_pkg::ST_OK) begin
            size_tab[live_total] = bytes;
            offset_tab[live_total] = heap_used[h][OFF_W-1:0];
            heap_tab[live_total] = h;
            heap_used[h] = heap_used[h] + bytes;
            r.assigned_id = ID_W'(live_total);
            r.heap_select = h;
            r.entry_offset = offset_tab[live_total];
            r.entry_bytes = bytes;
            live_total++;
         end
      end else if (oid >= live_total) begin
         r.status = cota_pkg::ST_ID;
      end else if (func == cota_pkg::FN_FREE) begin
         sz = size_tab[oid];
         h = heap_tab[oid];
         r.heap_select = h;
         r.entry_offset = offset_tab[oid];
         find_next(int'(oid), h, hit, at);
         if (hit) begin
            src = SIZE_W'(offset_tab[at]);
            r.move_source = src;
            r.move_dest = SIZE_W'(offset_tab[oid]);
            r.move_length = heap_used[h] - src;
            r.move_needed = r.move_length != 0;
         end
         heap_used[h] = heap_used[h] - sz;
         for (int k = int'(oid); k + 1 < live_total; k++) begin
            size_tab[k] = size_tab[k+1];
            heap_tab[k] = heap_tab[k+1];
            offset_tab[k] = offset_tab[k+1];
            if (heap_tab[k] == h) offset_tab[k] = offset_tab[k] - sz[OFF_W-1:0];
         end
         live_total--;
      end else if (func == cota_pkg::FN_RESIZE) begin
         sz = size_tab[oid];
         h = heap_tab[oid];
         if (bytes == sz) begin
            r.heap_select = h;
            r.entry_offset = offset_tab[oid];
            r.entry_bytes = sz;
         end else if (bytes == 0) begin
            r.status = cota_pkg::ST_SIZE;
         end else if (32'(heap_used[h]) - sz + bytes > cap_of(h)) begin
            r.status = cota_pkg::ST_SPACE;
         end else begin
            r.heap_select = h;
            r.entry_offset = offset_tab[oid];
            r.entry_bytes = bytes;
            find_next(int'(oid), h, hit, at);
            if (hit) begin
               src = SIZE_W'(offset_tab[at]);
               r.move_source = src;
               r.move_dest = src + bytes - sz;
               r.move_length = heap_used[h] - src;
               r.move_needed = r.move_length != 0;
            end
            heap_used[h] = heap_used[h] - sz + bytes;
            size_tab[oid] = bytes;
            for (int k = int'(oid) + 1; k < live_total; k++)
               if (heap_tab[k] == h)
                  offset_tab[k] = offset_tab[k] + bytes[OFF_W-1:0] - sz[OFF_W-1:0];
         end
      end else begin
         r.heap_select = heap_tab[oid];
         r.entry_offset = offset_tab[oid];
         r.entry_bytes = size_tab[oid];
      end
      r.live_count = CNT_W'(live_total);
      return r;
   endfunction

   task automatic write_register(input logic [1:0] index, input logic [SIZE_W-1:0] value);
      csr_index <= index;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (index == cota_pkg::REG_ALLOW) spill_enable = value[0];
      else limit_reg[index == cota_pkg::REG_SLIM] = value;
      @(negedge clock);
   endtask

   // wait for the block to drain before touching registers
   task automatic wait_idle();
      int guard;
      guard = 0;
      while (expected_rsp.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (150) @(negedge clock);
   endtask

   task automatic send_request(input logic [1:0] func, input logic [ID_W-1:0] oid,
                               input logic [SIZE_W-1:0] bytes, input bit fixed,
                               input logic [2:0] status);
      req_func <= func;
      req_object_id <= oid;
      req_byte_count <= bytes;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_rsp.push_back(predict_allocator(func, oid, bytes));
      fixed_valid.push_back(fixed);
      fixed_status.push_back(status);
      @(negedge clock);
   endtask

   task automatic idle_gap();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   function automatic logic [SIZE_W-1:0] random_size();
      case ($urandom_range(0, 9))
         0: return SIZE_W'($urandom_range(0, 2097151));
         1: return SIZE_W'(HEAP_BYTES);
         2: return '0;
         3, 4: return SIZE_W'($urandom_range(1, 16));
         default: return SIZE_W'($urandom_range(1, 4096));
      endcase
   endfunction

   // response checker
   always @(posedge clock) begin
      response_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_assigned_id, rsp_heap_select, rsp_entry_offset,
                 rsp_entry_bytes, rsp_move_needed, rsp_move_source, rsp_move_dest,
                 rsp_move_length, rsp_live_count};
         response_count++;
         if (rsp_move_needed) move_count++;
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected response", 32'(rsp_status), 0);
         end else begin
            want = expected_rsp.pop_front();
            if (fixed_valid.pop_front() && fixed_status[0] != want.status)
               report_mismatch("table status", 32'(want.status), 32'(fixed_status[0]));
            void'(fixed_status.pop_front());
            if (got.status != want.status)
               report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.assigned_id != want.assigned_id)
               report_mismatch("assigned_id", 32'(got.assigned_id), 32'(want.assigned_id));
            if (got.heap_select != want.heap_select)
               report_mismatch("heap_select", 32'(got.heap_select), 32'(want.heap_select));
            if (got.entry_offset != want.entry_offset)
               report_mismatch("entry_offset", 32'(got.entry_offset),
                               32'(want.entry_offset));
            if (got.entry_bytes != want.entry_bytes)
               report_mismatch("entry_bytes", 32'(got.entry_bytes), 32'(want.entry_bytes));
            if (got.move_needed != want.move_needed)
               report_mismatch("move_needed", 32'(got.move_needed), 32'(want.move_needed));
            if (got.move_source != want.move_source)
               report_mismatch("move_source", 32'(got.move_source), 32'(want.move_source));
            if (got.move_dest != want.move_dest)
               report_mismatch("move_dest", 32'(got.move_dest), 32'(want.move_dest));
            if (got.move_length != want.move_length)
               report_mismatch("move_length", 32'(got.move_length), 32'(want.move_length));
            if (got.live_count != want.live_count)
               report_mismatch("live_count", 32'(got.live_count), 32'(want.live_count));
         end
      end
   end

   // receiver stall pattern, with one long hold-off on request
   initial begin
      int mode;
      @(negedge clock);
      while (1) begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(1, 30)) begin
            rsp_ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, mode) == 0);
            @(negedge clock);
         end
      end
   end

   initial begin
      #50ms;
      $display("compacting_object_table_allocator_test: FAIL");
      $finish;
   end

   initial begin
      request_row_type rows [$];
      int burst;
      int kind;
      logic [ID_W-1:0] oid;
      for (int i = 0; i < MAX_OBJECTS; i++) begin
         size_tab[i] = '0;
         offset_tab[i] = '0;
         heap_tab[i] = 1'b0;
      end
      live_total = 0;
      heap_used[0] = '0;
      heap_used[1] = '0;
      spill_enable = 1'b0;
      limit_reg[0] = SIZE_W'(65536);
      limit_reg[1] = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: after reset, zero size, bad ids, limits, resize, free
      rows = '{
         '{cota_pkg::FN_READ,   6'd0,  21'd0,       1, cota_pkg::ST_ID},
         '{cota_pkg::FN_FREE,   6'd63, 21'd0,       1, cota_pkg::ST_ID},
         '{cota_pkg::FN_RESIZE, 6'd0,  21'd5,       1, cota_pkg::ST_ID},
         '{cota_pkg::FN_ADD,    6'd9,  21'd0,       1, cota_pkg::ST_SIZE},
         '{cota_pkg::FN_ADD,    6'd0,  21'd65537,   1, cota_pkg::ST_SPACE},
         '{cota_pkg::FN_ADD,    6'd0,  21'h1FFFFF,  1, cota_pkg::ST_SPACE},
         '{cota_pkg::FN_ADD,    6'd0,  21'd100,     1, cota_pkg::ST_OK},
         '{cota_pkg::FN_ADD,    6'd0,  21'd200,     1, cota_pkg::ST_OK},
         '{cota_pkg::FN_ADD,    6'd0,  21'd300,     1, cota_pkg::ST_OK},
         '{cota_pkg::FN_READ,   6'd1,  21'd0,       0, cota_pkg::ST_OK},
         '{cota_pkg::FN_RESIZE, 6'd0,  21'd100,     0, cota_pkg::ST_OK},
         '{cota_pkg::FN_RESIZE, 6'd0,  21'd0,       1, cota_pkg::ST_SIZE},
         '{cota_pkg::FN_RESIZE, 6'd0,  21'd150,     0, cota_pkg::ST_OK},
         '{cota_pkg::FN_RESIZE, 6'd1,  21'd10,      0, cota_pkg::ST_OK},
         '{cota_pkg::FN_RESIZE, 6'd2,  21'd70000,   1, cota_pkg::ST_SPACE},
         '{cota_pkg::FN_FREE,   6'd0,  21'd0,       0, cota_pkg::ST_OK},
         '{cota_pkg::FN_FREE,   6'd1,  21'd0,       0, cota_pkg::ST_OK},
         '{cota_pkg::FN_READ,   6'd1,  21'd0,       1, cota_pkg::ST_ID},
         '{cota_pkg::FN_ADD,    6'd0,  21'd65000,   0, cota_pkg::ST_OK},
         '{cota_pkg::FN_READ,   6'd0,  21'd0,       0, cota_pkg::ST_OK}
      };
      foreach (rows[i]) begin
         send_request(rows[i].func, rows[i].object_id, rows[i].byte_count,
                      rows[i].fixed, rows[i].status);
         if ($urandom_range(0, 2) == 0) idle_gap();
      end
      req_valid <= 1'b0;
      wait_idle();

      // spill into the secondary heap, then lower both limits
      write_register(cota_pkg::REG_ALLOW, 21'd1);
      write_register(cota_pkg::REG_SLIM, 21'h1FFFFF);
      send_request(cota_pkg::FN_ADD, 6'd0, 21'd4000, 0, cota_pkg::ST_OK);
      send_request(cota_pkg::FN_ADD, 6'd0, 21'd20, 0, cota_pkg::ST_OK);
      send_request(cota_pkg::FN_RESIZE, 6'd1, 21'd30, 0, cota_pkg::ST_OK);
      send_request(cota_pkg::FN_FREE, 6'd1, 21'd0, 0, cota_pkg::ST_OK);
      req_valid <= 1'b0;
      wait_idle();
      write_register(cota_pkg::REG_PLIM, 21'd0);
      write_register(cota_pkg::REG_SLIM, 21'd0);
      write_register(cota_pkg::REG_ALLOW, 21'd0);
      send_request(cota_pkg::FN_RESIZE, 6'd1, 21'd31, 1, cota_pkg::ST_SPACE);
      send_request(cota_pkg::FN_RESIZE, 6'd0, 21'd10, 0, cota_pkg::ST_OK);
      send_request(cota_pkg::FN_ADD, 6'd0, 21'd1, 1, cota_pkg::ST_SPACE);
      req_valid <= 1'b0;

      // random phases under several register settings
      for (int phase = 0; phase < 5; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               write_register(cota_pkg::REG_ALLOW, 21'd1);
               write_register(cota_pkg::REG_PLIM, 21'd20000);
               write_register(cota_pkg::REG_SLIM, 21'd30000);
            end
            1: begin
               write_register(cota_pkg::REG_PLIM, 21'h1FFFFF);
               write_register(cota_pkg::REG_SLIM, SIZE_W'(HEAP_BYTES));
            end
            2: begin
               write_register(cota_pkg::REG_ALLOW, 21'd0);
               write_register(cota_pkg::REG_PLIM, 21'd3000);
            end
            3: begin
               write_register(cota_pkg::REG_ALLOW, 21'd1);
               write_register(cota_pkg::REG_PLIM, 21'd500);
               write_register(cota_pkg::REG_SLIM, 21'd1000000);
            end
            default: begin
               write_register(cota_pkg::REG_PLIM, SIZE_W'($urandom_range(0, 2097151)));
               write_register(cota_pkg::REG_SLIM, SIZE_W'($urandom_range(0, 2097151)));
            end
         endcase
         if (phase == 1) hold_off = 1'b1;
         for (int n = 0; n < NUM_RANDOM / 5; ) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && n < NUM_RANDOM / 5; b++, n++) begin
               kind = $urandom_range(0, 99);
               // mostly valid ids, some one past the end, some anything
               if (live_total != 0 && kind % 10 < 8)
                  oid = ID_W'($urandom_range(0, live_total - 1));
               else if (kind % 10 == 8)
                  oid = ID_W'(live_total);
               else
                  oid = ID_W'($urandom_range(0, 63));
               if (kind < 45 - (phase == 1 ? 0 : 10))
                  send_request(cota_pkg::FN_ADD, ID_W'($urandom), random_size(), 0,
                               cota_pkg::ST_OK);
               else if (kind < 65)
                  send_request(cota_pkg::FN_FREE, oid, SIZE_W'($urandom), 0,
                               cota_pkg::ST_OK);
               else if (kind < 85)
                  send_request(cota_pkg::FN_RESIZE, oid,
                               ($urandom_range(0, 5) == 0 && oid < live_total) ?
                               size_tab[oid] : random_size(), 0, cota_pkg::ST_OK);
               else
                  send_request(cota_pkg::FN_READ, oid, SIZE_W'($urandom), 0,
                               cota_pkg::ST_OK);
            end
            if ($urandom_range(0, 3) != 0) idle_gap();
         end
         req_valid <= 1'b0;
      end

      wait_idle();
      $display("covered %0d responses, %0d with a heap move, final live count %0d",
               response_count, move_count, live_total);
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("compacting_object_table_allocator_test: PASS");
      end else begin
         $display("compacting_object_table_allocator_test: FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
src/cota_pkg.sv
src/compacting_object_table_allocator.sv
dv/compacting_object_table_allocator_test.sv
